// ===== hdl/rar_pkg.sv =====
// shared types, constants and helpers for the ultrasonic range alarm
package rar_pkg;

   // width of every time value; times wrap modulo 2**TIME_BITS
   localparam int TIME_BITS = 32;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam int DIST_BITS = 16;
   localparam logic [DIST_BITS-1:0] DIST_MAX = 16'hFFFF;
   localparam logic [DIST_BITS-1:0] DIST_RESET = 16'd400;

   // echo width is tracked as quotient and remainder of a division by 58
   localparam int ECHO_DIVISOR = 58;
   localparam int REM_BITS = 6;
   localparam logic [REM_BITS-1:0] REM_LAST = REM_BITS'(ECHO_DIVISOR - 1);
   localparam int QUO_BITS = 17;
   localparam logic [QUO_BITS-1:0] QUO_MAX = 17'h10000;
   // widest echo that still yields no more than full scale with a multiplier of one
   localparam longint unsigned ECHO_SAT_LIMIT = 64'(65535 * ECHO_DIVISOR + ECHO_DIVISOR - 1);

   // multiplier times ceil(2**RECIP_SHIFT / 58): exact for remainder terms
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_SCALE = ((1 << RECIP_SHIFT) + ECHO_DIVISOR - 1) / ECHO_DIVISOR;
   localparam int RECIP_BITS = 23;

   typedef logic [TIME_BITS-1:0] tick_time_type;

   typedef enum logic [2:0] {
      REG_ALARM_DISTANCE   = 3'd0,
      REG_RANGE_MULTIPLIER = 3'd1,
      REG_TRIGGER_WIDTH    = 3'd2,
      REG_TRIGGER_PERIOD   = 3'd3,
      REG_ECHO_TIMEOUT     = 3'd4,
      REG_ALARM_HOLDOFF    = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic echo_level;
      logic alarm_acknowledged;
      logic alarm_forced;
   } req_type;

   typedef struct packed {
      logic                 trigger_level;
      logic [DIST_BITS-1:0] distance_cm;
      logic                 alarm_pulse;
   } rsp_type;

   typedef struct packed {
      logic [15:0]           alarm_distance;
      logic [7:0]            range_multiplier;
      logic [RECIP_BITS-1:0] range_recip;
      logic [15:0]           trigger_width;
      logic [23:0]           trigger_period;
      logic [23:0]           echo_timeout;
      logic [25:0]           alarm_holdoff;
   } cfg_type;

   function automatic tick_time_type time_add(tick_time_type t, logic [31:0] d);
      logic [64:0] sum;
      sum = 65'(t) + 65'(d);
      return sum[TIME_BITS-1:0];
   endfunction

   function automatic logic [RECIP_BITS-1:0] recip_of(logic [7:0] mult);
      logic [31:0] prod;
      prod = 32'(mult) * 32'(RECIP_SCALE);
      return prod[RECIP_BITS-1:0];
   endfunction

endpackage

// ===== hdl/ultrasonic_range_alarm.sv =====
// ultrasonic range alarm: trigger timing, echo ranging and alarm pulses per tick
//
// usage
//   req channel: one beat per microsecond tick with the sampled echo level and the
//   acknowledge and force flags. rsp channel: exactly one beat per req beat with the
//   trigger pin level, the latest distance in cm and the alarm pulse flag.
//   configuration goes through the apb-style port, register i at byte address 4*i;
//   write it only while no beat is in flight.
// timing
//   a req beat lands in the input register, is processed combinationally by rar_core
//   into the rsp register and is offered from there while rsp_valid is high.
//   one beat per cycle is sustained while rsp_ready stays high; the rate is set
//   by rar_core, which updates its whole state for each beat that it steps.
// reset
//   synchronous, active high: the tick count and all times go to zero, distance to
//   400 cm, registers to their defaults, both pipeline registers empty.
// stall
//   while rsp_ready is low the rsp beat holds and one more req beat is taken into the
//   input register; after that req_ready drops until the rsp beat is taken.
module ultrasonic_range_alarm import rar_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // input channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   // configuration port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   cfg_type cfg;

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff, in_item_in;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   rsp_type core_result;
   logic    advance;

   rar_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // the held beat moves on when the result register is empty or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   rar_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_item_in  = req_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/rar_csr.sv =====
// configuration registers behind the apb-style port
module rar_csr import rar_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output cfg_type                  cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          wr_en;
   reg_index_type reg_index;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite && pready;
   assign reg_index = reg_index_type'(paddr[CSR_ADDR_BITS-1:2]);
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            REG_ALARM_DISTANCE:   cfg_in.alarm_distance = pwdata[15:0];
            REG_RANGE_MULTIPLIER: begin
               cfg_in.range_multiplier = pwdata[7:0];
               cfg_in.range_recip      = recip_of(pwdata[7:0]);
            end
            REG_TRIGGER_WIDTH:    cfg_in.trigger_width  = pwdata[15:0];
            REG_TRIGGER_PERIOD:   cfg_in.trigger_period = pwdata[23:0];
            REG_ECHO_TIMEOUT:     cfg_in.echo_timeout   = pwdata[23:0];
            REG_ALARM_HOLDOFF:    cfg_in.alarm_holdoff  = pwdata[25:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alarm_distance   <= 16'd0;
         cfg_ff.range_multiplier <= 8'd1;
         cfg_ff.range_recip      <= recip_of(8'd1);
         cfg_ff.trigger_width    <= 16'd10;
         cfg_ff.trigger_period   <= 24'd60000;
         cfg_ff.echo_timeout     <= 24'd500000;
         cfg_ff.alarm_holdoff    <= 26'd1000000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_index)
         REG_ALARM_DISTANCE:   prdata = 32'(cfg_ff.alarm_distance);
         REG_RANGE_MULTIPLIER: prdata = 32'(cfg_ff.range_multiplier);
         REG_TRIGGER_WIDTH:    prdata = 32'(cfg_ff.trigger_width);
         REG_TRIGGER_PERIOD:   prdata = 32'(cfg_ff.trigger_period);
         REG_ECHO_TIMEOUT:     prdata = 32'(cfg_ff.echo_timeout);
         REG_ALARM_HOLDOFF:    prdata = 32'(cfg_ff.alarm_holdoff);
         default:              prdata = '0;
      endcase
   end

endmodule

// ===== hdl/rar_core.sv =====
// per-tick trigger, echo ranging and alarm state update
module rar_core import rar_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   tick_time_type tick_ff, tick_in;
   tick_time_type trig_end_ff, trig_end_in;
   tick_time_type trig_next_ff, trig_next_in;
   tick_time_type echo_start_ff, echo_start_in;
   tick_time_type lost_ff, lost_in;
   tick_time_type ready_ff, ready_in;
   logic [DIST_BITS-1:0] dist_ff, dist_in;
   logic echo_active_ff, echo_active_in;
   logic trig_ff, trig_in;
   logic [QUO_BITS-1:0] quo_ff, quo_in;
   logic [REM_BITS-1:0] rem_ff, rem_in;

   tick_time_type           elapsed;
   logic [QUO_BITS-1:0]     quo_step;
   logic [REM_BITS-1:0]     rem_step;
   logic [24:0]             big_prod;
   logic [REM_BITS+RECIP_BITS-1:0] small_prod;
   logic [24:0]             dist_sum;
   logic [DIST_BITS-1:0]    dist_calc;
   logic                    cond;
   logic                    pulse;

   // echo width held as quotient and remainder by 58, advanced one tick at a time
   assign elapsed = tick_ff - echo_start_ff;

   always_comb begin
      if (elapsed == '0) begin
         quo_step = '0;
         rem_step = '0;
      end else if (rem_ff == REM_LAST) begin
         rem_step = '0;
         quo_step = (quo_ff == QUO_MAX) ? quo_ff : quo_ff + 1'b1;
      end else begin
         rem_step = rem_ff + 1'b1;
         quo_step = quo_ff;
      end
   end

   // mult * width / 58 = mult * quotient + mult * remainder / 58
   assign big_prod   = 25'(cfg.range_multiplier) * 25'(quo_step);
   assign small_prod = (REM_BITS+RECIP_BITS)'(rem_step) * (REM_BITS+RECIP_BITS)'(cfg.range_recip);
   assign dist_sum   = big_prod + 25'(small_prod[REM_BITS+RECIP_BITS-1:RECIP_SHIFT]);

   always_comb begin
      if (cfg.range_multiplier == 8'd0) begin
         dist_calc = '0;
      end else if (64'(elapsed) > ECHO_SAT_LIMIT || dist_sum > 25'(DIST_MAX)) begin
         dist_calc = DIST_MAX;
      end else begin
         dist_calc = dist_sum[DIST_BITS-1:0];
      end
   end

   always_comb begin
      trig_in        = trig_ff;
      trig_end_in    = trig_end_ff;
      trig_next_in   = trig_next_ff;
      echo_start_in  = echo_start_ff;
      lost_in        = lost_ff;
      ready_in       = ready_ff;
      dist_in        = dist_ff;
      echo_active_in = echo_active_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      pulse          = 1'b0;

      if (tick_ff >= trig_end_ff) begin
         trig_in = 1'b0;
      end
      if (tick_ff >= trig_next_ff) begin
         trig_in      = 1'b1;
         trig_end_in  = time_add(tick_ff, 32'(cfg.trigger_width));
         trig_next_in = time_add(tick_ff, 32'(cfg.trigger_period));
      end

      if (!echo_active_ff && item.echo_level) begin
         lost_in        = time_add(tick_ff, 32'(cfg.echo_timeout));
         echo_start_in  = tick_ff;
         echo_active_in = 1'b1;
         quo_in         = '0;
         rem_in         = '0;
      end else if (echo_active_ff) begin
         quo_in = quo_step;
         rem_in = rem_step;
         if (!item.echo_level) begin
            dist_in        = dist_calc;
            echo_active_in = 1'b0;
         end
      end

      cond = ((dist_in < cfg.alarm_distance || lost_in < tick_ff) && !item.alarm_acknowledged)
             || item.alarm_forced;
      if (cond && tick_ff > ready_ff) begin
         ready_in = time_add(tick_ff, 32'(cfg.alarm_holdoff));
         pulse    = 1'b1;
      end

      tick_in = tick_ff + 1'b1;
   end

   assign result.trigger_level = trig_in;
   assign result.distance_cm   = dist_in;
   assign result.alarm_pulse   = pulse;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff        <= '0;
         trig_end_ff    <= '0;
         trig_next_ff   <= '0;
         echo_start_ff  <= '0;
         lost_ff        <= '0;
         ready_ff       <= '0;
         dist_ff        <= DIST_RESET;
         echo_active_ff <= 1'b0;
         trig_ff        <= 1'b0;
         quo_ff         <= '0;
         rem_ff         <= '0;
      end else if (step) begin
         tick_ff        <= tick_in;
         trig_end_ff    <= trig_end_in;
         trig_next_ff   <= trig_next_in;
         echo_start_ff  <= echo_start_in;
         lost_ff        <= lost_in;
         ready_ff       <= ready_in;
         dist_ff        <= dist_in;
         echo_active_ff <= echo_active_in;
         trig_ff        <= trig_in;
         quo_ff         <= quo_in;
         rem_ff         <= rem_in;
      end
   end

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the ultrasonic range alarm: predictor, scoreboard and stimulus
module testbench;
   import rar_pkg::*;

   localparam int CLOCK_HALF = 5;
   localparam int RESET_CYCLES = 4;
   // idle margin after every expected rsp beat is back
   localparam int SETTLE_CYCLES = 6;
   localparam int LONG_HOLD = 400;
   localparam longint unsigned CYCLE_LIMIT = 1000000;
   localparam int MAX_REPORTS = 100;

   localparam int CM_DIVISOR = 58;
   localparam logic [15:0] CM_FULL_SCALE = 16'hFFFF;
   localparam logic [15:0] CM_AT_RESET = 16'd400;

   // register slots past the defined list, writes there must change nothing
   localparam logic [2:0] SPARE_INDEX_LO = 3'd6;
   localparam logic [2:0] SPARE_INDEX_HI = 3'd7;

   // opening ticks as {echo_level, alarm_acknowledged, alarm_forced}
   localparam logic [2:0] OPENING_TICKS [18] = '{
      3'b001,  // forced on tick zero, not yet past the holdoff time
      3'b000,  // lost deadline still zero after reset, alarm fires
      3'b001,  // forced inside the holdoff
      3'b010,
      3'b011,
      3'b011,  // forced past the holdoff despite acknowledge
      3'b100,  // echo rises, deadline armed
      3'b110,
      3'b110,
      3'b110,
      3'b010,  // echo falls, trigger drops at its end time
      3'b100,
      3'b000,  // one-tick echo
      3'b111,
      3'b111,
      3'b000,
      3'b000,
      3'b010
   };

   typedef enum int {
      STALL_NONE,
      STALL_HALF,
      STALL_SPARSE,
      STALL_HEAVY
   } stall_mode_type;

   typedef struct {
      logic [15:0] alarm_distance;
      logic [7:0]  range_multiplier;
      logic [15:0] trigger_width;
      logic [23:0] trigger_period;
      logic [23:0] echo_timeout;
      logic [25:0] alarm_holdoff;
      int          ticks;
      int          long_echo;  // leading ticks with the echo held high
   } range_setting_type;

   // predicts one rsp beat per tick and checks the beats that come back
   class range_alarm_scoreboard_type;
      logic [15:0]   alarm_distance;
      logic [7:0]    range_multiplier;
      logic [15:0]   trigger_width;
      logic [23:0]   trigger_period;
      logic [23:0]   echo_timeout;
      logic [25:0]   alarm_holdoff;

      tick_time_type tick_count;
      tick_time_type trigger_end_time;
      tick_time_type next_trigger_time;
      tick_time_type echo_start_time;
      tick_time_type lost_deadline;
      tick_time_type alarm_ready_time;
      logic [15:0]   last_distance;
      bit            echo_active;
      bit            trigger_state;

      rsp_type       expected_beats[$];
      int unsigned   errors;
      int unsigned   beats_checked;
      int unsigned   alarm_count;
      int unsigned   saturated_count;

      function new();
         alarm_distance    = 16'd0;
         range_multiplier  = 8'd1;
         trigger_width     = 16'd10;
         trigger_period    = 24'd60000;
         echo_timeout      = 24'd500000;
         alarm_holdoff     = 26'd1000000;
         tick_count        = '0;
         trigger_end_time  = '0;
         next_trigger_time = '0;
         echo_start_time   = '0;
         lost_deadline     = '0;
         alarm_ready_time  = '0;
         last_distance     = CM_AT_RESET;
         echo_active       = 1'b0;
         trigger_state     = 1'b0;
         errors            = 0;
         beats_checked     = 0;
         alarm_count       = 0;
         saturated_count   = 0;
      endfunction

      function void write_register(logic [2:0] index, logic [31:0] value);
         case (index)
            REG_ALARM_DISTANCE:   alarm_distance   = value[15:0];
            REG_RANGE_MULTIPLIER: range_multiplier = value[7:0];
            REG_TRIGGER_WIDTH:    trigger_width    = value[15:0];
            REG_TRIGGER_PERIOD:   trigger_period   = value[23:0];
            REG_ECHO_TIMEOUT:     echo_timeout     = value[23:0];
            REG_ALARM_HOLDOFF:    alarm_holdoff    = value[25:0];
            default: ;
         endcase
      endfunction

      // echo width in ticks to cm, saturated at full scale
      function logic [15:0] echo_to_cm(tick_time_type width);
         logic [39:0] scaled;
         scaled = (40'(range_multiplier) * 40'(width)) / 40'(CM_DIVISOR);
         if (scaled > 40'(CM_FULL_SCALE))
            return CM_FULL_SCALE;
         return scaled[15:0];
      endfunction

      function void note_tick(req_type item);
         rsp_type       beat;
         tick_time_type now;
         bit            alarm_wanted;
         now = tick_count;
         beat.alarm_pulse = 1'b0;

         if (now >= trigger_end_time)
            trigger_state = 1'b0;
         if (now >= next_trigger_time) begin
            trigger_state     = 1'b1;
            trigger_end_time  = now + tick_time_type'(trigger_width);
            next_trigger_time = now + tick_time_type'(trigger_period);
         end

         if (!echo_active && item.echo_level) begin
            lost_deadline   = now + tick_time_type'(echo_timeout);
            echo_start_time = now;
            echo_active     = 1'b1;
         end else if (echo_active && !item.echo_level) begin
            last_distance = echo_to_cm(now - echo_start_time);
            echo_active   = 1'b0;
            if (last_distance == CM_FULL_SCALE)
               saturated_count++;
         end

         alarm_wanted = ((last_distance < alarm_distance || lost_deadline < now)
                         && !item.alarm_acknowledged) || item.alarm_forced;
         if (alarm_wanted && now > alarm_ready_time) begin
            alarm_ready_time = now + tick_time_type'(alarm_holdoff);
            beat.alarm_pulse = 1'b1;
            alarm_count++;
         end

         tick_count         = now + 1;
         beat.trigger_level = trigger_state;
         beat.distance_cm   = last_distance;
         expected_beats.push_back(beat);
      endfunction

      function void check_beat(rsp_type got);
         rsp_type want;
         if (expected_beats.size() == 0) begin
            if (errors < MAX_REPORTS)
               $error("rsp beat with nothing expected: %p", got);
            errors++;
            return;
         end
         want = expected_beats.pop_front();
         beats_checked++;
         if (got.trigger_level !== want.trigger_level) begin
            if (errors < MAX_REPORTS)
               $error("trigger_level: expected %0d, actual %0d",
                      want.trigger_level, got.trigger_level);
            errors++;
         end
         if (got.distance_cm !== want.distance_cm) begin
            if (errors < MAX_REPORTS)
               $error("distance_cm: expected %0d, actual %0d",
                      want.distance_cm, got.distance_cm);
            errors++;
         end
         if (got.alarm_pulse !== want.alarm_pulse) begin
            if (errors < MAX_REPORTS)
               $error("alarm_pulse: expected %0d, actual %0d",
                      want.alarm_pulse, got.alarm_pulse);
            errors++;
         end
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_type                  req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_type                  rsp_data;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   range_alarm_scoreboard_type board;
   longint unsigned       cycles = 0;
   bit                    pressure_armed = 1'b0;
   bit                    pressure_done = 1'b0;
   int                    burst_left = 0;
   bit                    echo_level_now = 1'b0;
   int                    echo_run_left = 0;
   int                    settings_applied = 0;

   ultrasonic_range_alarm dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
   end

   initial begin : watchdog
      while (cycles < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d beats still expected", cycles, board.pending());
      $display("testbench: FAIL");
      $finish;
   end

   // rsp side: handshake decided from values that settled by the falling edge
   initial begin : rsp_monitor
      rsp_type beat;
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            beat = rsp_data;
            @(posedge clock);
            board.check_beat(beat);
         end
      end
   end

   // rsp_ready pattern: segments of varied stalling, one long hold-off when armed
   initial begin : rsp_stall_pattern
      stall_mode_type mode;
      int             seg_len;
      @(posedge clock);
      forever begin
         if (pressure_armed && !pressure_done) begin
            // long hold while the sender keeps offering, fills the block
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            pressure_done = 1'b1;
         end
         mode    = stall_mode_type'($urandom_range(0, 3));
         seg_len = $urandom_range(8, 80);
         repeat (seg_len) begin
            case (mode)
               STALL_NONE:   rsp_ready <= 1'b1;
               STALL_HALF:   rsp_ready <= 1'($urandom_range(0, 1));
               STALL_SPARSE: rsp_ready <= ($urandom_range(0, 7) != 0);
               STALL_HEAVY:  rsp_ready <= ($urandom_range(0, 3) == 0);
               default:      rsp_ready <= 1'b1;
            endcase
            @(posedge clock);
         end
      end
   end

   // one apb write, setup then access, then psel dropped to idle before returning
   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      bit done;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      done = 1'b0;
      while (!done) begin
         @(negedge clock);
         done = (pready === 1'b1);
         @(posedge clock);
      end
      board.write_register(index, value);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // offer one tick beat, with bursts and gaps on the sender side
   task automatic offer_tick(input req_type item);
      int  gap;
      bit  accepted;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      accepted = 1'b0;
      while (!accepted) begin
         @(negedge clock);
         accepted = (req_ready === 1'b1);
         @(posedge clock);
      end
      board.note_tick(item);
   endtask

   // drop valid and wait until every expected beat is back
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly well-formed echo pulses, some one-tick glitches and long runs
   task automatic make_tick(output req_type item);
      int pick;
      if (echo_run_left == 0) begin
         echo_level_now = !echo_level_now;
         pick = $urandom_range(0, 19);
         if (pick < 2)
            echo_run_left = 1;
         else if (pick == 2)
            echo_run_left = $urandom_range(100, 300);
         else
            echo_run_left = $urandom_range(2, 40);
      end
      echo_run_left--;
      item.echo_level         = echo_level_now;
      item.alarm_acknowledged = ($urandom_range(0, 9) < 3);
      item.alarm_forced       = ($urandom_range(0, 7) == 0);
   endtask

   task automatic run_phase(input range_setting_type s);
      req_type     item;
      logic [31:0] junk;
      settle();
      // upper data bits are random, the registers keep only their own width
      junk = $urandom;
      csr_write(REG_ALARM_DISTANCE,   {junk[31:16], s.alarm_distance});
      csr_write(REG_RANGE_MULTIPLIER, {junk[31:8],  s.range_multiplier});
      csr_write(REG_TRIGGER_WIDTH,    {junk[31:16], s.trigger_width});
      csr_write(REG_TRIGGER_PERIOD,   {junk[31:24], s.trigger_period});
      csr_write(REG_ECHO_TIMEOUT,     {junk[31:24], s.echo_timeout});
      csr_write(REG_ALARM_HOLDOFF,    {junk[31:26], s.alarm_holdoff});
      csr_write(SPARE_INDEX_LO, $urandom);
      csr_write(SPARE_INDEX_HI, $urandom);
      settings_applied++;
      // the long rsp hold-off starts once the first setting is streaming ticks
      if (settings_applied == 1)
         pressure_armed = 1'b1;
      for (int i = 0; i < s.ticks; i++) begin
         make_tick(item);
         if (i < s.long_echo) begin
            item.echo_level = 1'b1;
            echo_level_now  = 1'b1;
            echo_run_left   = 1;
         end
         offer_tick(item);
      end
   endtask

   initial begin : stimulus
      range_setting_type s;
      board = new();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // short holdoff and period first: the reset values would stall alarms
      // and triggers far beyond the length of this run
      csr_write(REG_ALARM_HOLDOFF, 32'd3);
      csr_write(REG_TRIGGER_PERIOD, 32'd25);
      for (int i = 0; i < 18; i++)
         offer_tick(req_type'(OPENING_TICKS[i]));

      // near-threshold ranging, short timeout, start of the long rsp hold-off
      s = '{alarm_distance: 16'd150, range_multiplier: 8'd200, trigger_width: 16'd3,
            trigger_period: 24'd40, echo_timeout: 24'd30, alarm_holdoff: 26'd5,
            ticks: 250, long_echo: 0};
      run_phase(s);

      // all-zero timing, zero multiplier, widest alarm distance
      s = '{alarm_distance: 16'hFFFF, range_multiplier: 8'd0, trigger_width: 16'd0,
            trigger_period: 24'd0, echo_timeout: 24'd0, alarm_holdoff: 26'd0,
            ticks: 200, long_echo: 0};
      run_phase(s);

      // largest width and timeout, full multiplier, alarm distance off
      s = '{alarm_distance: 16'd0, range_multiplier: 8'hFF, trigger_width: 16'hFFFF,
            trigger_period: 24'd7, echo_timeout: 24'hFFFFFF, alarm_holdoff: 26'd1,
            ticks: 200, long_echo: 0};
      run_phase(s);

      for (int p = 0; p < 4; p++) begin
         s.alarm_distance   = 16'($urandom_range(0, 300));
         s.range_multiplier = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
         s.trigger_width    = 16'($urandom_range(0, 60));
         s.trigger_period   = 24'($urandom_range(0, 120));
         s.echo_timeout     = 24'($urandom_range(0, 400));
         s.alarm_holdoff    = 26'($urandom_range(0, 50));
         s.ticks            = 150;
         s.long_echo        = 0;
         run_phase(s);
      end

      // largest period and holdoff last: each fires once and then stays quiet
      s = '{alarm_distance: 16'($urandom_range(0, 300)),
            range_multiplier: 8'($urandom_range(1, 255)), trigger_width: 16'd1,
            trigger_period: 24'hFFFFFF, echo_timeout: 24'd100,
            alarm_holdoff: 26'h3FFFFFF, ticks: 200, long_echo: 0};
      run_phase(s);

      settle();

      $display("summary: %0d tick beats checked over %0d register settings",
               board.beats_checked, settings_applied);
      $display("summary: %0d alarm pulses, %0d saturated readings, %0d mismatches",
               board.alarm_count, board.saturated_count, board.errors);
      if (board.errors == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/rar_pkg.sv
hdl/rar_csr.sv
hdl/rar_core.sv
hdl/ultrasonic_range_alarm.sv
sim/testbench.sv
